### design/cmf1_pkg.sv
`timescale 1ns / 1ps
// Package for the macro-F1 confusion-matrix unit.
// Shared constants for the interfaces and top level; no dependencies.
package cmf1_pkg;
    localparam int MAX_CLASSES       = 16;
    localparam int COUNT_BITS        = 32;
    localparam int SCORE_FRAC_BITS   = 16;
    localparam int CLASS_BITS        = 4;
    localparam int CFG_BITS          = 5;
    localparam int TOTAL_BITS        = 32;
    localparam int MIN_CLASSES       = 2;
    localparam logic [CFG_BITS-1:0] CLASS_COUNT_RESET = 5'd16;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX       = 32'hFFFF_FFFF;
endpackage

### design/cmf1_in_if.sv
`timescale 1ns / 1ps
// Request channel of the macro-F1 unit: one classification per request.
// Depends on cmf1_pkg.
interface cmf1_in_if;
    logic                            valid;
    logic                            ready;
    logic [cmf1_pkg::CLASS_BITS-1:0] true_class;
    logic [cmf1_pkg::CLASS_BITS-1:0] predicted_class;
    logic                            last;

    modport source (output valid, true_class, predicted_class, last, input ready);
    modport sink   (input valid, true_class, predicted_class, last, output ready);
endinterface

### design/cmf1_out_if.sv
`timescale 1ns / 1ps
// Result channel of the macro-F1 unit: one score per batch.
// Depends on cmf1_pkg.
interface cmf1_out_if #(
    parameter int FRAC_BITS = cmf1_pkg::SCORE_FRAC_BITS
);
    logic                            valid;
    logic                            ready;
    logic [FRAC_BITS:0]              macro_f1;
    logic [cmf1_pkg::TOTAL_BITS-1:0] sample_total;

    modport source (output valid, macro_f1, sample_total, input ready);
    modport sink   (input valid, macro_f1, sample_total, output ready);
endinterface

### design/cmf1_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmf1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/confusion_matrix_macro_f1_unit.sv
`timescale 1ns / 1ps
// Macro-F1 over a confusion matrix. Depends on cmf1_pkg, cmf1_in_if, cmf1_out_if, cmf1_ram.
// Throughput: one recorded request per cycle while ready is high (RAM read, then modify/write
// with forwarding). A last request blocks input: its write, then per class address and load
// plus SCORE_FRAC_BITS+1 divider steps when TP is nonzero, then a start and SCORE_FRAC_BITS+1+
// $clog2(MAX_CLASSES+1) average steps (shared divider), then the result load once it is free.
// Reset (async, rst_n low): all counts read as zero, class_count = 16, no result pending.
module confusion_matrix_macro_f1_unit #(
    parameter int MAX_CLASSES     = cmf1_pkg::MAX_CLASSES,
    parameter int COUNT_BITS      = cmf1_pkg::COUNT_BITS,
    parameter int SCORE_FRAC_BITS = cmf1_pkg::SCORE_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cmf1_pkg::CFG_BITS-1:0] cfg_wr_data,
    cmf1_in_if.sink                       req,
    cmf1_out_if.source                    res
);
    // Widths derived from the parameters.
    localparam int AW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;   // class address
    localparam int NW   = $clog2(MAX_CLASSES + 1);                        // class count
    localparam int CMPW = (NW > cmf1_pkg::CLASS_BITS) ? NW : cmf1_pkg::CLASS_BITS;
    localparam int EW   = (NW > cmf1_pkg::CFG_BITS) ? NW : cmf1_pkg::CFG_BITS;
    localparam int DW   = COUNT_BITS + 2;                 // divisor / remainder
    localparam int QF   = SCORE_FRAC_BITS + 1;            // score width
    localparam int SUMW = QF + NW;                        // sum of scores
    localparam int CW   = $clog2(SUMW + 1);               // divider step count
    localparam int TOTW = (COUNT_BITS > cmf1_pkg::TOTAL_BITS) ? COUNT_BITS
                                                              : cmf1_pkg::TOTAL_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Report sequencer codes.
    localparam logic [2:0] ST_RUN    = 3'd0;  // recording requests
    localparam logic [2:0] ST_ADDR   = 3'd1;  // present class address to RAMs
    localparam logic [2:0] ST_LOAD   = 3'd2;  // read data back, start per-class divide
    localparam logic [2:0] ST_F1DIV  = 3'd3;  // per-class F1 divide steps
    localparam logic [2:0] ST_AVG    = 3'd4;  // start average divide
    localparam logic [2:0] ST_AVGDIV = 3'd5;  // average divide steps
    localparam logic [2:0] ST_DONE   = 3'd6;  // hand result over, clear counts

    logic [2:0] state_reg, state_next;

    // ---------------------------------------------------------------
    // Configuration and effective class count (clamped to 2..MAX).
    // ---------------------------------------------------------------
    logic [cmf1_pkg::CFG_BITS-1:0] class_count_reg;
    logic [EW-1:0]                 cc_ext;
    logic [NW-1:0]                 n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= cmf1_pkg::CLASS_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            class_count_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        cc_ext = EW'(class_count_reg);
        if (cc_ext < EW'(cmf1_pkg::MIN_CLASSES))
        begin
            n_eff = NW'(cmf1_pkg::MIN_CLASSES);
        end
        else if (cc_ext > EW'(MAX_CLASSES))
        begin
            n_eff = NW'(MAX_CLASSES);
        end
        else
        begin
            n_eff = cc_ext[NW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: accept request, issue RAM reads.
    // Only the diagonal cells feed the score, so the matrix is kept as
    // its diagonal (tp) plus the row and column totals.
    // ---------------------------------------------------------------
    logic          s1_valid_reg, s1_rec_reg, s1_last_reg;
    logic [AW-1:0] s1_t_reg, s1_p_reg;
    logic [CMPW-1:0] t_ext, p_ext;
    logic            req_rec, req_fire;

    assign req.ready = (state_reg == ST_RUN) && !(s1_valid_reg && s1_last_reg);
    assign req_fire  = req.valid && req.ready;
    assign t_ext     = CMPW'(req.true_class);
    assign p_ext     = CMPW'(req.predicted_class);
    assign req_rec   = (t_ext < CMPW'(n_eff)) && (p_ext < CMPW'(n_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_rec_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req_fire;
            s1_rec_reg   <= req_fire && req_rec;
            s1_last_reg  <= req_fire && req.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_t_reg <= t_ext[AW-1:0];
            s1_p_reg <= p_ext[AW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Count RAMs: diagonal, row totals, column totals.
    // ---------------------------------------------------------------
    logic [AW-1:0]         rpt_c_reg, rpt_c_next;
    logic [AW-1:0]         tp_raddr, row_raddr, col_raddr;
    logic [COUNT_BITS-1:0] tp_rdata, row_rdata, col_rdata;
    logic                  tp_we, row_we, col_we;
    logic [COUNT_BITS-1:0] tp_wdata, row_wdata, col_wdata;

    always_comb
    begin
        if (state_reg == ST_RUN)
        begin
            tp_raddr  = t_ext[AW-1:0];
            row_raddr = t_ext[AW-1:0];
            col_raddr = p_ext[AW-1:0];
        end
        else
        begin
            tp_raddr  = rpt_c_reg;
            row_raddr = rpt_c_reg;
            col_raddr = rpt_c_reg;
        end
    end

    cmf1_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CLASSES)) u_tp_ram (
        .clk(clk), .we(tp_we), .waddr(s1_t_reg), .wdata(tp_wdata),
        .raddr(tp_raddr), .rdata(tp_rdata)
    );
    cmf1_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CLASSES)) u_row_ram (
        .clk(clk), .we(row_we), .waddr(s1_t_reg), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );
    cmf1_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CLASSES)) u_col_ram (
        .clk(clk), .we(col_we), .waddr(s1_p_reg), .wdata(col_wdata),
        .raddr(col_raddr), .rdata(col_rdata)
    );

    // Per-entry valid bits: a cleared entry reads as zero.
    logic [MAX_CLASSES-1:0] tp_vld_reg, row_vld_reg, col_vld_reg;
    // Forwarding of the write done at the same edge as the current read.
    logic                  tp_fw_v_reg, row_fw_v_reg, col_fw_v_reg;
    logic [AW-1:0]         tp_fw_a_reg, row_fw_a_reg, col_fw_a_reg;
    logic [COUNT_BITS-1:0] tp_fw_d_reg, row_fw_d_reg, col_fw_d_reg;
    logic [COUNT_BITS-1:0] batch_reg;
    logic                  clear_all;

    // ---------------------------------------------------------------
    // Stage 1: modify and write back.
    // ---------------------------------------------------------------
    logic [COUNT_BITS-1:0] tp_old, row_old, col_old;
    logic                  s1_diag;

    assign s1_diag = (s1_t_reg == s1_p_reg);

    always_comb
    begin
        if (tp_fw_v_reg && (tp_fw_a_reg == s1_t_reg))
        begin
            tp_old = tp_fw_d_reg;
        end
        else
        begin
            tp_old = tp_vld_reg[s1_t_reg] ? tp_rdata : '0;
        end
        if (row_fw_v_reg && (row_fw_a_reg == s1_t_reg))
        begin
            row_old = row_fw_d_reg;
        end
        else
        begin
            row_old = row_vld_reg[s1_t_reg] ? row_rdata : '0;
        end
        if (col_fw_v_reg && (col_fw_a_reg == s1_p_reg))
        begin
            col_old = col_fw_d_reg;
        end
        else
        begin
            col_old = col_vld_reg[s1_p_reg] ? col_rdata : '0;
        end
    end

    assign row_we    = s1_rec_reg;
    assign col_we    = s1_rec_reg;
    assign tp_we     = s1_rec_reg && s1_diag;
    assign tp_wdata  = (tp_old == CNT_MAX) ? CNT_MAX : tp_old + 1'b1;
    assign row_wdata = (row_old == CNT_MAX) ? CNT_MAX : row_old + 1'b1;
    assign col_wdata = (col_old == CNT_MAX) ? CNT_MAX : col_old + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_vld_reg   <= '0;
            row_vld_reg  <= '0;
            col_vld_reg  <= '0;
            tp_fw_v_reg  <= 1'b0;
            row_fw_v_reg <= 1'b0;
            col_fw_v_reg <= 1'b0;
            batch_reg    <= '0;
        end
        else if (clear_all)
        begin
            tp_vld_reg   <= '0;
            row_vld_reg  <= '0;
            col_vld_reg  <= '0;
            tp_fw_v_reg  <= 1'b0;
            row_fw_v_reg <= 1'b0;
            col_fw_v_reg <= 1'b0;
            batch_reg    <= '0;
        end
        else
        begin
            tp_fw_v_reg  <= tp_we;
            row_fw_v_reg <= row_we;
            col_fw_v_reg <= col_we;
            if (tp_we)
            begin
                tp_vld_reg[s1_t_reg] <= 1'b1;
            end
            if (row_we)
            begin
                row_vld_reg[s1_t_reg] <= 1'b1;
            end
            if (col_we)
            begin
                col_vld_reg[s1_p_reg] <= 1'b1;
            end
            if (s1_rec_reg && (batch_reg != CNT_MAX))
            begin
                batch_reg <= batch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tp_fw_a_reg  <= s1_t_reg;
        tp_fw_d_reg  <= tp_wdata;
        row_fw_a_reg <= s1_t_reg;
        row_fw_d_reg <= row_wdata;
        col_fw_a_reg <= s1_p_reg;
        col_fw_d_reg <= col_wdata;
    end

    // ---------------------------------------------------------------
    // Report: walk the classes through one shared restoring divider.
    // F1: remainder starts at TP, zeros shifted in, QF steps gives
    //     floor(2*TP*2^F / (TP+row+col)).
    // Average: remainder starts at 0, sum shifted in, SUMW steps.
    // ---------------------------------------------------------------
    logic [DW-1:0]   div_rem_reg, div_rem_next;
    logic [DW-1:0]   div_den_reg, div_den_next;
    logic [SUMW-1:0] div_num_reg, div_num_next;
    logic [SUMW-1:0] div_q_reg, div_q_next;
    logic [CW-1:0]   div_cnt_reg, div_cnt_next;
    logic [SUMW-1:0] sum_reg, sum_next;
    logic [QF-1:0]   score_reg, score_next;

    logic [DW:0]     step_rem2;
    logic            step_ge;
    logic [DW-1:0]   step_rem;
    logic [SUMW-1:0] step_q;
    logic            step_done;

    logic [COUNT_BITS-1:0] rd_tp, rd_row, rd_col;
    logic                  rpt_last_class;

    assign step_rem2 = {div_rem_reg, div_num_reg[SUMW-1]};
    assign step_ge   = (step_rem2 >= {1'b0, div_den_reg});
    assign step_rem  = step_ge ? DW'(step_rem2 - {1'b0, div_den_reg}) : step_rem2[DW-1:0];
    assign step_q    = {div_q_reg[SUMW-2:0], step_ge};
    assign step_done = (div_cnt_reg == CW'(1));

    assign rd_tp  = tp_vld_reg[rpt_c_reg]  ? tp_rdata  : '0;
    assign rd_row = row_vld_reg[rpt_c_reg] ? row_rdata : '0;
    assign rd_col = col_vld_reg[rpt_c_reg] ? col_rdata : '0;
    assign rpt_last_class = ({1'b0, rpt_c_reg} == (AW + 1)'(n_eff - 1'b1));

    always_comb
    begin
        state_next   = state_reg;
        rpt_c_next   = rpt_c_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        div_num_next = div_num_reg;
        div_q_next   = div_q_reg;
        div_cnt_next = div_cnt_reg;
        sum_next     = sum_reg;
        score_next   = score_reg;
        clear_all    = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (s1_valid_reg && s1_last_reg)
                begin
                    state_next = ST_ADDR;
                    rpt_c_next = '0;
                    sum_next   = '0;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (rd_tp == '0)
                begin
                    // No true positives: score is zero, no divide.
                    if (rpt_last_class)
                    begin
                        state_next = ST_AVG;
                    end
                    else
                    begin
                        rpt_c_next = rpt_c_reg + 1'b1;
                        state_next = ST_ADDR;
                    end
                end
                else
                begin
                    div_rem_next = DW'(rd_tp);
                    div_den_next = DW'(rd_tp) + DW'(rd_row) + DW'(rd_col);
                    div_num_next = '0;
                    div_q_next   = '0;
                    div_cnt_next = CW'(QF);
                    state_next   = ST_F1DIV;
                end
            end
            ST_F1DIV:
            begin
                div_rem_next = step_rem;
                div_num_next = {div_num_reg[SUMW-2:0], 1'b0};
                div_q_next   = step_q;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (step_done)
                begin
                    sum_next = sum_reg + SUMW'(step_q[QF-1:0]);
                    if (rpt_last_class)
                    begin
                        state_next = ST_AVG;
                    end
                    else
                    begin
                        rpt_c_next = rpt_c_reg + 1'b1;
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_AVG:
            begin
                div_rem_next = '0;
                div_den_next = DW'(n_eff);
                div_num_next = sum_reg;
                div_q_next   = '0;
                div_cnt_next = CW'(SUMW);
                state_next   = ST_AVGDIV;
            end
            ST_AVGDIV:
            begin
                div_rem_next = step_rem;
                div_num_next = {div_num_reg[SUMW-2:0], 1'b0};
                div_q_next   = step_q;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (step_done)
                begin
                    score_next = step_q[QF-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Wait for a free result register, then clear the batch.
                if (!res.valid || res.ready)
                begin
                    clear_all  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpt_c_reg   <= rpt_c_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_num_reg <= div_num_next;
        div_q_reg   <= div_q_next;
        div_cnt_reg <= div_cnt_next;
        sum_reg     <= sum_next;
        score_reg   <= score_next;
    end

    // ---------------------------------------------------------------
    // Result register; sample total saturates to the 32-bit field.
    // ---------------------------------------------------------------
    logic                                res_valid_reg;
    logic [QF-1:0]                       res_f1_reg;
    logic [cmf1_pkg::TOTAL_BITS-1:0]     res_total_reg;
    logic [TOTW-1:0]                     batch_ext;
    logic [cmf1_pkg::TOTAL_BITS-1:0]     batch_sat;

    assign batch_ext = TOTW'(batch_reg);
    assign batch_sat = (batch_ext > TOTW'(cmf1_pkg::TOTAL_MAX)) ? cmf1_pkg::TOTAL_MAX
                                                                : batch_ext[cmf1_pkg::TOTAL_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (clear_all)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_all)
        begin
            res_f1_reg    <= score_reg;
            res_total_reg <= batch_sat;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.macro_f1     = res_f1_reg;
    assign res.sample_total = res_total_reg;
endmodule
